FILE: hdl/upn_pkg.sv
// Shared types and constants for the Unix path normalizer.
package upn_pkg;

	localparam int MAX_LEN_DEF = 256;
	localparam int MAX_SEG_DEF = 128;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_CHAR = 2'd0;
	localparam logic [1:0] CMD_END  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [7:0] SLASH_CHAR = 8'h2F;
	localparam logic [7:0] DOT_CHAR   = 8'h2E;

	typedef enum logic [2:0] {
		OP_CHAR  = 3'd0,
		OP_DOT   = 3'd1,
		OP_SLASH = 3'd2,
		OP_END   = 3'd3,
		OP_READ  = 3'd4
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] ch;
	} op_t;

endpackage

FILE: hdl/upn_front.sv
// Front stage: accepts input items and classifies them into operations.
module upn_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,   // [1:0] cmd
	input  logic [7:0]       s_tdata,   // [7:0] char_in
	output logic             op_valid,
	input  logic             op_ready,
	output upn_pkg::op_t     op
);
	import upn_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	logic keep;
	op_t  cls;

	assign s_tready = !valid_s1 || op_ready;
	assign op_valid = valid_s1;
	assign op       = op_s1;

	always_comb begin
		keep    = 1'b1;
		cls.ch  = s_tdata;
		cls.kind = OP_CHAR;
		unique case (s_tuser)
			CMD_CHAR: begin
				if (s_tdata == SLASH_CHAR) begin
					cls.kind = OP_SLASH;
				end else if (s_tdata == DOT_CHAR) begin
					cls.kind = OP_DOT;
				end else begin
					cls.kind = OP_CHAR;
				end
			end
			CMD_END:  cls.kind = OP_END;
			CMD_READ: cls.kind = OP_READ;
			default:  keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= cls;
		end
	end

endmodule

FILE: hdl/upn_queue.sv
// Short operation queue between the front and back stages.
module upn_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  upn_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output upn_pkg::op_t pop_op
);
	import upn_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: hdl/upn_back.sv
// Back stage: builds the canonical path in the result store and emits results.
module upn_back #(
	parameter int MAX_LEN      = upn_pkg::MAX_LEN_DEF,
	parameter int MAX_SEGMENTS = upn_pkg::MAX_SEG_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_valid,
	output logic         op_ready,
	input  upn_pkg::op_t op,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_char,
	output logic         out_last,
	output logic [8:0]   out_length,
	output logic         out_overflow
);
	import upn_pkg::*;

	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int AW  = $clog2(MAX_LEN);
	localparam int DW  = $clog2(MAX_SEGMENTS + 1);
	localparam int SAW = $clog2(MAX_SEGMENTS);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_POP  = 3'b010,
		B_RD   = 3'b100
	} back_state_t;

	function automatic logic [LW-1:0] final_len(input logic [LW-1:0] l);
		return (l > LW'(1)) ? l - LW'(1) : LW'(1);
	endfunction

	back_state_t state_q, state_n;
	logic [LW-1:0] len_q, len_n;
	logic [LW-1:0] cur_q, cur_n;
	logic [DW-1:0] depth_q, depth_n;
	logic [1:0]    dot_q, dot_n;
	logic [LW-1:0] rp_q, rp_n;
	logic          fin_q, fin_n;
	logic          ovf_q, ovf_n;
	logic          end_pend_q, end_pend_n;
	logic          rd_zero_q, rd_zero_n;
	logic          rd_last_q, rd_last_n;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;
	logic [8:0]    out_len_q;
	logic          out_ovf_q;
	logic          emit;
	logic [7:0]    emit_char;
	logic          emit_last;
	logic [8:0]    emit_len;
	logic          emit_ovf;

	logic [7:0]    store_mem [MAX_LEN];
	logic [7:0]    store_rd_q;
	logic          store_we;
	logic [AW-1:0] store_wa;
	logic [7:0]    store_wd;

	logic [LW-1:0] stack_mem [MAX_SEGMENTS];
	logic [LW-1:0] stack_rd_q;
	logic          stack_we;
	logic          stack_re;
	logic [SAW-1:0] stack_wa;
	logic [SAW-1:0] stack_ra;

	logic          take;
	logic          is_path;
	logic          fresh;
	logic [LW-1:0] len_e;
	logic [LW-1:0] cur_e;
	logic [DW-1:0] depth_e;
	logic [DW-1:0] depth_dec;
	logic [1:0]    dot_e;
	logic          ovf_e;
	logic [LW-1:0] fl;

	assign is_path  = (op.kind == OP_CHAR) || (op.kind == OP_DOT) || (op.kind == OP_SLASH);
	assign take     = (state_q == B_IDLE) && op_valid && (is_path || !out_valid_q);
	assign op_ready = take;
	assign fresh    = is_path && fin_q;

	// A path character after an end command starts a new path from reset values.
	assign len_e     = fresh ? LW'(1) : len_q;
	assign cur_e     = fresh ? LW'(1) : cur_q;
	assign depth_e   = fresh ? '0 : depth_q;
	assign dot_e     = fresh ? 2'd0 : dot_q;
	assign ovf_e     = fresh ? 1'b0 : ovf_q;
	assign fl        = final_len(len_q);
	assign depth_dec = depth_e - DW'(1);

	always_comb begin
		state_n    = state_q;
		len_n      = len_q;
		cur_n      = cur_q;
		depth_n    = depth_q;
		dot_n      = dot_q;
		rp_n       = rp_q;
		fin_n      = fin_q;
		ovf_n      = ovf_q;
		end_pend_n = end_pend_q;
		rd_zero_n  = rd_zero_q;
		rd_last_n  = rd_last_q;
		store_we   = 1'b0;
		store_wa   = len_e[AW-1:0];
		store_wd   = op.ch;
		stack_we   = 1'b0;
		stack_re   = 1'b0;
		stack_wa   = depth_e[SAW-1:0];
		stack_ra   = depth_dec[SAW-1:0];
		emit       = 1'b0;
		emit_char  = '0;
		emit_last  = 1'b0;
		emit_len   = '0;
		emit_ovf   = ovf_q;

		unique case (state_q)
			B_IDLE: begin
				if (take) begin
					if (is_path) begin
						len_n   = len_e;
						cur_n   = cur_e;
						depth_n = depth_e;
						dot_n   = dot_e;
						ovf_n   = ovf_e;
						if (fresh) begin
							rp_n  = '0;
							fin_n = 1'b0;
						end
					end
					case (op.kind)
						OP_CHAR, OP_DOT: begin
							if (len_e < LW'(MAX_LEN)) begin
								store_we = 1'b1;
								len_n    = len_e + LW'(1);
							end else begin
								ovf_n = 1'b1;
							end
							dot_n = (op.kind == OP_DOT && dot_e <= 2'd1) ? dot_e + 2'd1 : 2'd3;
						end
						OP_SLASH, OP_END: begin
							if (op.kind == OP_SLASH || !fin_q) begin
								dot_n = 2'd0;
								case (dot_e)
									2'd1: len_n = cur_e;
									2'd2: begin
										len_n = cur_e;
										if (depth_e != '0) begin
											depth_n    = depth_e - DW'(1);
											stack_re   = 1'b1;
											end_pend_n = op.kind == OP_END;
											state_n    = B_POP;
										end
									end
									2'd3: begin
										if (len_e >= LW'(MAX_LEN) ||
										    depth_e >= DW'(MAX_SEGMENTS)) begin
											ovf_n = 1'b1;
											len_n = cur_e;
										end else begin
											store_we = 1'b1;
											store_wd = SLASH_CHAR;
											len_n    = len_e + LW'(1);
											stack_we = 1'b1;
											depth_n  = depth_e + DW'(1);
											cur_n    = len_e + LW'(1);
										end
									end
									default: ;
								endcase
							end
							if (op.kind == OP_END && state_n == B_IDLE) begin
								fin_n    = 1'b1;
								if (!fin_q) begin
									rp_n = '0;
								end
								emit     = 1'b1;
								emit_len = 9'(final_len(len_n));
								emit_ovf = ovf_n;
							end
						end
						OP_READ: begin
							if (fin_q && rp_q < fl) begin
								rd_zero_n = rp_q == '0;
								rd_last_n = (rp_q + LW'(1)) == fl;
								rp_n      = rp_q + LW'(1);
								state_n   = B_RD;
							end
						end
						default: ;
					endcase
				end
			end
			B_POP: begin
				len_n   = stack_rd_q;
				cur_n   = stack_rd_q;
				state_n = B_IDLE;
				if (end_pend_q) begin
					fin_n    = 1'b1;
					rp_n     = '0;
					emit     = 1'b1;
					emit_len = 9'(final_len(stack_rd_q));
				end
			end
			B_RD: begin
				emit      = 1'b1;
				emit_char = rd_zero_q ? SLASH_CHAR : store_rd_q;
				emit_last = rd_last_q;
				state_n   = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			len_q       <= LW'(1);
			cur_q       <= LW'(1);
			depth_q     <= '0;
			dot_q       <= 2'd0;
			rp_q        <= '0;
			fin_q       <= 1'b0;
			ovf_q       <= 1'b0;
			end_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			len_q      <= len_n;
			cur_q      <= cur_n;
			depth_q    <= depth_n;
			dot_q      <= dot_n;
			rp_q       <= rp_n;
			fin_q      <= fin_n;
			ovf_q      <= ovf_n;
			end_pend_q <= end_pend_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_zero_q <= rd_zero_n;
		rd_last_q <= rd_last_n;
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
			out_len_q  <= emit_len;
			out_ovf_q  <= emit_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_wa] <= store_wd;
		end
		store_rd_q <= store_mem[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_wa] <= cur_e;
		end
		if (stack_re) begin
			stack_rd_q <= stack_mem[stack_ra];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_last     = out_last_q;
	assign out_length   = out_len_q;
	assign out_overflow = out_ovf_q;

endmodule

FILE: hdl/unix_path_normalizer.sv
// Top level of the Unix absolute path normalizer.
//
// The block takes an absolute Unix path one character per item and builds
// its canonical form: runs of slashes collapse, "." segments vanish and ".."
// removes the previous segment (at the root it does nothing). An end item
// closes the path and returns its length and the overflow flag; read items
// then return the canonical path one character each, with tlast on the final
// character. A path character arriving after an end item starts a new path.
// A front stage registers and classifies each item, a two-entry queue holds
// the classified operations, and the back stage carries them out against the
// result store and the segment-start stack. The back stage finishes a plain
// path character or slash in the B_IDLE state; a ".." that pops the segment
// stack also passes through B_POP for the registered stack read, and a read
// item passes through B_RD for the registered result store read. An item that
// returns a result starts only once the output register is empty, which it is
// again after the sink takes the previous result, so a read cannot start
// before the result of the one before it has been taken, and a stalled sink
// holds reads back further. Items with cmd 3 are discarded in the front stage.
// No clearing pass is needed after reset.
module unix_path_normalizer #(
	parameter int MAX_LEN      = upn_pkg::MAX_LEN_DEF,
	parameter int MAX_SEGMENTS = upn_pkg::MAX_SEG_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_char, [16:8] out_length, [17] overflow
	output logic        m_tlast    // out_last
);
	import upn_pkg::*;

	op_t        front_op;
	logic       front_valid;
	logic       front_ready;
	op_t        back_op;
	logic       back_valid;
	logic       back_ready;
	logic [7:0] out_char;
	logic [8:0] out_length;
	logic       out_overflow;

	// Front stage: registers the item and turns it into an operation.
	upn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.op_valid (front_valid),
		.op_ready (front_ready),
		.op       (front_op)
	);

	// The queue lets the front keep accepting while the back waits on memory
	// or on the sink.
	upn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_op    (front_op),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_op     (back_op)
	);

	upn_back #(
		.MAX_LEN      (MAX_LEN),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (back_valid),
		.op_ready     (back_ready),
		.op           (back_op),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (out_char),
		.out_last     (m_tlast),
		.out_length   (out_length),
		.out_overflow (out_overflow)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_tdata = {6'd0, out_overflow, out_length, out_char};

endmodule

FILE: tb/tb_unix_path_normalizer.sv
// Self-checking testbench for the Unix path normalizer stream block.
module tb_unix_path_normalizer;
	import upn_pkg::*;

	// Budget of the run. The slowest correct item is a read that waits out a
	// sink stall and a source gap on top of its own processing, so about 2000
	// items fit inside the cycle limit.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int CALM_TAIL    = 250;
	localparam int DRAIN_CYCLES = 20;
	localparam int SCRIPT_ROWS  = 27;

	// The fourth command code has no name in the package; the block drops it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Classification of the segment that is still open.
	typedef enum logic [1:0] {
		SEG_EMPTY  = 2'd0,
		SEG_DOT    = 2'd1,
		SEG_DOTDOT = 2'd2,
		SEG_NAME   = 2'd3
	} seg_kind_t;

	// One reply of the block, one field per member.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [8:0] length;
		logic       ovf;
	} reply_t;

	// One row of the directed script; typed rows carry their reply by hand.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic       typed;
		reply_t     reply;
	} script_row_t;

	localparam reply_t NO_REPLY = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic [7:0]  s_tdata;   // [7:0] char_in
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [7:0] out_char, [16:8] out_length, [17] overflow
	logic        m_tlast;   // out_last

	// Shadow of the canonical path being built, kept in step with the block.
	logic [7:0] canon_store [0:MAX_LEN_DEF-1];
	logic [8:0] canon_len;
	logic [8:0] seg_stack [0:MAX_SEG_DEF-1];
	logic [7:0] seg_depth;
	logic [8:0] seg_open;
	seg_kind_t  seg_kind;
	logic [8:0] read_pos;
	logic       path_closed;
	logic       path_ovf;

	reply_t      replies_due [$];
	script_row_t script [0:SCRIPT_ROWS-1];
	int          mismatches = 0;
	int          items_fed = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	bit          quiet = 1'b0;

	unix_path_normalizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Back to the empty root path. Store entries past the root are never read
	// before they are written, so they are left alone.
	function automatic void canon_clear();
		canon_store[0] = SLASH_CHAR;
		canon_len = 9'd1;
		seg_depth = 8'd0;
		seg_open = 9'd1;
		seg_kind = SEG_EMPTY;
		read_pos = 9'd0;
		path_closed = 1'b0;
		path_ovf = 1'b0;
	endfunction

	// Reported length: the trailing slash is not counted, and the bare root
	// still counts as one character.
	function automatic logic [8:0] canon_final_len();
		return (canon_len > 9'd1) ? canon_len - 9'd1 : 9'd1;
	endfunction

	function automatic void close_segment();
		case (seg_kind)
			SEG_DOT: begin
				canon_len = seg_open;
			end
			SEG_DOTDOT: begin
				canon_len = seg_open;
				// At the root there is nothing to pop.
				if (seg_depth > 8'd0) begin
					seg_depth = seg_depth - 8'd1;
					seg_open = seg_stack[seg_depth];
					canon_len = seg_open;
				end
			end
			SEG_NAME: begin
				// A name whose slash does not fit is dropped whole.
				if (canon_len >= MAX_LEN_DEF || seg_depth >= MAX_SEG_DEF) begin
					path_ovf = 1'b1;
					canon_len = seg_open;
				end else begin
					canon_store[canon_len] = SLASH_CHAR;
					canon_len = canon_len + 9'd1;
					seg_stack[seg_depth] = seg_open;
					seg_depth = seg_depth + 8'd1;
					seg_open = canon_len;
				end
			end
			default: begin
			end
		endcase
		seg_kind = SEG_EMPTY;
	endfunction

	function automatic void take_path_char(input logic [7:0] ch);
		if (ch == SLASH_CHAR) begin
			close_segment();
		end else begin
			if (canon_len < MAX_LEN_DEF) begin
				canon_store[canon_len] = ch;
				canon_len = canon_len + 9'd1;
			end else begin
				path_ovf = 1'b1;
			end
			// Only one or two dots make a special segment; three is a name.
			if (ch == DOT_CHAR && (seg_kind == SEG_EMPTY || seg_kind == SEG_DOT))
				seg_kind = seg_kind_t'(seg_kind + 2'd1);
			else
				seg_kind = SEG_NAME;
		end
	endfunction

	// Applies one accepted item to the shadow path; returns 1 with the reply
	// when the item causes one.
	function automatic bit canon_apply(input logic [1:0] cmd, input logic [7:0] ch,
			output reply_t r);
		logic [8:0] fl;
		r = NO_REPLY;
		case (cmd)
			CMD_CHAR: begin
				// A path character after an end starts a fresh path.
				if (path_closed)
					canon_clear();
				take_path_char(ch);
				return 1'b0;
			end
			CMD_END: begin
				// A repeated end only repeats the report.
				if (!path_closed) begin
					close_segment();
					path_closed = 1'b1;
					read_pos = 9'd0;
				end
				r.length = canon_final_len();
				r.ovf = path_ovf;
				return 1'b1;
			end
			CMD_READ: begin
				if (!path_closed)
					return 1'b0;
				fl = canon_final_len();
				if (read_pos >= fl || read_pos >= MAX_LEN_DEF)
					return 1'b0;
				r.ch = canon_store[read_pos];
				r.last = (read_pos + 9'd1 == fl);
				r.ovf = path_ovf;
				read_pos = read_pos + 9'd1;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Drives one item from a falling edge, waits for the handshake, predicts,
	// and returns at the next falling edge. A random gap may come first.
	task automatic feed(input logic [1:0] cmd, input logic [7:0] ch, input logic typed,
			input reply_t typed_reply);
		reply_t r;
		bit     has_reply;
		if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		has_reply = canon_apply(cmd, ch, r);
		if (has_reply)
			replies_due = {replies_due, (typed ? typed_reply : r)};
		items_fed++;
		@(negedge clk);
	endtask

	task automatic feed_plain(input logic [1:0] cmd, input logic [7:0] ch);
		feed(cmd, ch, 1'b0, NO_REPLY);
	endtask

	// One path with random segments, then an end and a drain. A few paths are
	// long enough to overrun the store; some are abandoned or half drained.
	task automatic feed_random_path();
		bit         long_path;
		int         nseg;
		int         nlen;
		int         pick;
		logic [8:0] fl;
		logic [7:0] c;
		long_path = ($urandom_range(0, 24) == 0);
		calm = ($urandom_range(0, 3) == 0);
		nseg = long_path ? $urandom_range(40, 90) : $urandom_range(0, 7);
		// Now and then the leading slash is left out.
		if ($urandom_range(0, 5) != 0)
			feed_plain(CMD_CHAR, SLASH_CHAR);
		for (int k = 0; k < nseg; k++) begin
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				feed_plain(CMD_CHAR, DOT_CHAR);
			end else if (pick < 6) begin
				repeat (2) feed_plain(CMD_CHAR, DOT_CHAR);
			end else if (pick == 6) begin
				repeat (3) feed_plain(CMD_CHAR, DOT_CHAR);
			end else if (pick == 7) begin
				feed_plain(CMD_UNUSED, 8'($urandom_range(0, 255)));
			end else if (pick == 8) begin
				feed_plain(CMD_READ, 8'($urandom_range(0, 255)));
			end else begin
				nlen = $urandom_range(1, 6);
				for (int j = 0; j < nlen; j++) begin
					pick = $urandom_range(0, 7);
					if (pick < 5)
						c = 8'h61 + 8'($urandom_range(0, 25));
					else if (pick == 5)
						c = DOT_CHAR;
					else
						c = 8'($urandom_range(0, 255));
					feed_plain(CMD_CHAR, c);
				end
			end
			if (k != nseg - 1 || $urandom_range(0, 1) == 1)
				repeat (($urandom_range(0, 3) == 0) ? 2 : 1) feed_plain(CMD_CHAR, SLASH_CHAR);
		end
		// An unfinished path simply runs on into the next one.
		if ($urandom_range(0, 9) == 0)
			return;
		feed_plain(CMD_END, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0)
			feed_plain(CMD_END, 8'h00);
		fl = canon_final_len();
		nlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, fl) : fl + $urandom_range(0, 2);
		repeat (nlen) feed_plain(CMD_READ, 8'($urandom_range(0, 255)));
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Stimulus: reset, the directed script, then random paths until the item
	// count is reached; the tail runs without any idling.
	initial begin
		s_tvalid = 1'b0;
		s_tuser = CMD_CHAR;
		s_tdata = 8'h00;
		arst_n = 1'b0;

		// Root after reset, a drained read and the unused command.
		script[0]  = {CMD_END, 8'h00, 1'b1, 8'h00, 1'b0, 9'd1, 1'b0};
		script[1]  = {CMD_READ, 8'h00, 1'b1, SLASH_CHAR, 1'b1, 9'd0, 1'b0};
		script[2]  = {CMD_READ, 8'h00, 1'b0, NO_REPLY};
		script[3]  = {CMD_UNUSED, 8'hFF, 1'b0, NO_REPLY};
		// New path after the end: ".." at the root, then extreme bytes,
		// a doubled slash, a "." segment and a read before the end.
		script[4]  = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[5]  = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[6]  = {CMD_CHAR, SLASH_CHAR, 1'b0, NO_REPLY};
		script[7]  = {CMD_CHAR, 8'hFF, 1'b0, NO_REPLY};
		script[8]  = {CMD_CHAR, SLASH_CHAR, 1'b0, NO_REPLY};
		script[9]  = {CMD_CHAR, SLASH_CHAR, 1'b0, NO_REPLY};
		script[10] = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[11] = {CMD_CHAR, SLASH_CHAR, 1'b0, NO_REPLY};
		script[12] = {CMD_CHAR, 8'h00, 1'b0, NO_REPLY};
		script[13] = {CMD_READ, 8'h00, 1'b0, NO_REPLY};
		// Three dots form an ordinary name.
		script[14] = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[15] = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[16] = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[17] = {CMD_END, 8'h00, 1'b0, NO_REPLY};
		script[18] = {CMD_END, 8'h00, 1'b0, NO_REPLY};
		script[19] = {CMD_READ, 8'h00, 1'b0, NO_REPLY};
		script[20] = {CMD_READ, 8'h00, 1'b0, NO_REPLY};
		script[21] = {CMD_READ, 8'h00, 1'b0, NO_REPLY};
		// A relative path whose only name is popped leaves the root.
		script[22] = {CMD_CHAR, 8'h62, 1'b0, NO_REPLY};
		script[23] = {CMD_CHAR, SLASH_CHAR, 1'b0, NO_REPLY};
		script[24] = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[25] = {CMD_CHAR, DOT_CHAR, 1'b0, NO_REPLY};
		script[26] = {CMD_END, 8'h00, 1'b1, 8'h00, 1'b0, 9'd1, 1'b0};

		canon_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < SCRIPT_ROWS; i++)
			feed(script[i].cmd, script[i].ch, script[i].typed, script[i].reply);
		while (items_fed < SCRIPT_ROWS + RANDOM_ITEMS) begin
			quiet = (items_fed > SCRIPT_ROWS + RANDOM_ITEMS - CALM_TAIL);
			feed_random_path();
		end
		s_tvalid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			$display("%0t: %0d replies never arrived", $time, replies_due.size());
		if (mismatches == 0 && replies_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Sink: ready is held low in random bursts, except in calm stretches and
	// in the tail of the run.
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall = $urandom_range(1, 18) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every reply taken is checked against the oldest one due.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: reply with none due, expected nothing, actual tdata 0x%0h tlast %b",
					$time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("out_char", want.ch, m_tdata[7:0]);
				check_field("out_length", want.length, m_tdata[16:8]);
				check_field("overflow", want.ovf, m_tdata[17]);
				check_field("tdata padding", 0, m_tdata[23:18]);
				check_field("out_last", want.last, m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule

FILE: sim.f
hdl/upn_pkg.sv
hdl/upn_front.sv
hdl/upn_queue.sv
hdl/upn_back.sv
hdl/unix_path_normalizer.sv
tb/tb_unix_path_normalizer.sv
